@@ rtl/scan_code_key_slot_allocator_defines.svh @@
// Assertion macros used by the top level to check this block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SCAN_CODE_KEY_SLOT_ALLOCATOR_DEFINES_SVH
`define SCAN_CODE_KEY_SLOT_ALLOCATOR_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define SCKSLOT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define SCKSLOT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sckslot_pkg.sv @@
`default_nettype none
package sckslot_pkg;

  // Slot table size and field widths.
  localparam int SLOTS   = 10;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;

  // Decoupling queue between classifier and slot engine.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  // Scan code constants.
  localparam logic [BYTE_W-1:0] CODE_MIN     = 8'h10;
  localparam logic [BYTE_W-1:0] CODE_MAX     = 8'h5F;
  localparam logic [BYTE_W-1:0] BREAK_PREFIX = 8'hF0;
  localparam logic [BYTE_W-1:0] TRACK_BASE   = 8'h15;
  localparam logic [BYTE_W-1:0] UNUSED_CODE  = 8'hFF;

  // Result event kinds.
  localparam logic [KIND_W-1:0] EV_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] EV_PRESS   = 2'd1;
  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;
  localparam logic [KIND_W-1:0] EV_FULL    = 2'd3;

  // Operations passed from the classifier to the slot engine.
  localparam logic [1:0] OP_NONE    = 2'd0;
  localparam logic [1:0] OP_PRESS   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] track;
  } op_t;

  // Status of the slot engine, watched by the top level.
  typedef struct packed {
    logic [CNT_W-1:0] free_count;
    logic             busy;
  } back_stat_t;

endpackage
`default_nettype wire

@@ rtl/sckslot_in_if.sv @@
`default_nettype none
interface sckslot_in_if;
  import sckslot_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/sckslot_out_if.sv @@
`default_nettype none
interface sckslot_out_if;
  import sckslot_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [SLOT_W-1:0] slot;
  logic [BYTE_W-1:0] track_index;

  modport source (output valid, output event_kind, output slot, output track_index,
                  input ready);
  modport sink (input valid, input event_kind, input slot, input track_index,
                output ready);
endinterface
`default_nettype wire

@@ rtl/sckslot_front.sv @@
`default_nettype none
module sckslot_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  sckslot_in_if.sink        in_ch,
  input  wire logic         q_full,
  output logic              q_push,
  output sckslot_pkg::op_t  q_data
);
  import sckslot_pkg::*;

  logic              break_pending_r;
  logic              break_pending_nxt;
  logic              accept;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] hi;
  logic [BYTE_W-1:0] shift;

  // Items are taken whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.scan_byte;

  // Track mapping: code - 0x15 - 2 * (high nibble - 1), wrapping at 8 bits.
  assign hi    = {4'b0000, b[7:4]};
  assign shift = BYTE_W'((hi - 8'd1) << 1);

  // Classify the byte as a press, a release or nothing.
  always_comb begin
    q_data.code  = b;
    q_data.track = b - TRACK_BASE - shift;
    if (b inside {[CODE_MIN:CODE_MAX]}) begin
      q_data.op = break_pending_r ? OP_RELEASE : OP_PRESS;
    end else begin
      q_data.op = OP_NONE;
    end
  end

  assign q_push            = accept;
  assign break_pending_nxt = (b == BREAK_PREFIX);

  // The break prefix only affects the byte right after it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      break_pending_r <= 1'b0;
    end else if (accept) begin
      break_pending_r <= break_pending_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/sckslot_queue.sv @@
`default_nettype none
module sckslot_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire sckslot_pkg::op_t  push_data,
  output logic                   full,
  input  wire logic              pop,
  output sckslot_pkg::op_t       pop_data,
  output logic                   empty
);
  import sckslot_pkg::*;

  op_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/sckslot_back.sv @@
`default_nettype none
module sckslot_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_empty,
  input  wire sckslot_pkg::op_t      q_data,
  output logic                       q_pop,
  sckslot_out_if.source              out_ch,
  output sckslot_pkg::back_stat_t    stat
);
  import sckslot_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_r;
  op_t               op_r;
  logic [SLOT_W-1:0] k_r;
  logic              hit_r;
  logic [SLOT_W-1:0] hit_slot_r;
  logic [BYTE_W-1:0] slot_code_r [SLOTS];
  logic [SLOT_W-1:0] free_stack_r [SLOTS];
  logic [CNT_W-1:0]  free_count_r;

  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [BYTE_W-1:0] out_track_r;

  logic              out_free;
  logic              finish;
  logic [CNT_W-1:0]  pop_pos;
  logic [SLOT_W-1:0] pop_slot;

  assign out_free = !out_valid_r || out_ch.ready;
  assign finish   = (state_r == ST_DONE) && out_free;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign pop_pos  = free_count_r - 1'b1;
  assign pop_slot = free_stack_r[pop_pos[SLOT_W-1:0]];

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_kind  = out_kind_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.track_index = out_track_r;

  assign stat.free_count = free_count_r;
  assign stat.busy       = (state_r != ST_IDLE);

  // Sequencer: take an operation, scan the slots one per cycle for a press or a release, then apply it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      hit_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            k_r     <= '0;
            hit_r   <= 1'b0;
            state_r <= (q_data.op == OP_NONE) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!hit_r && slot_code_r[k_r] == op_r.code) begin
            hit_r <= 1'b1;
          end
          if (k_r == SLOT_W'(SLOTS - 1)) begin
            state_r <= ST_DONE;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Operation and match position hold no control meaning before use.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r <= q_data;
    end
    if (state_r == ST_SCAN && !hit_r && slot_code_r[k_r] == op_r.code) begin
      hit_slot_r <= k_r;
    end
  end

  // Slot table and free stack are updated when the result is issued.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_code_r[i]  <= UNUSED_CODE;
        free_stack_r[i] <= SLOT_W'(i);
      end
      free_count_r <= CNT_W'(SLOTS);
    end else if (finish) begin
      if (op_r.op == OP_RELEASE && hit_r) begin
        slot_code_r[hit_slot_r] <= UNUSED_CODE;
        if (free_count_r < CNT_W'(SLOTS)) begin
          free_stack_r[free_count_r[SLOT_W-1:0]] <= hit_slot_r;
          free_count_r <= free_count_r + 1'b1;
        end
      end else if (op_r.op == OP_PRESS && !hit_r && free_count_r != '0) begin
        free_count_r <= pop_pos;
        if ({1'b0, pop_slot} < CNT_W'(SLOTS)) begin
          slot_code_r[pop_slot] <= op_r.code;
        end
      end
    end
  end

  // Result register: holds one item until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result fields; an item with no event carries zero slot and track.
  always_ff @(posedge clk) begin
    if (finish) begin
      if (op_r.op == OP_RELEASE && hit_r) begin
        out_kind_r  <= EV_RELEASE;
        out_slot_r  <= hit_slot_r;
        out_track_r <= op_r.track;
      end else if (op_r.op == OP_PRESS && !hit_r && free_count_r == '0) begin
        out_kind_r  <= EV_FULL;
        out_slot_r  <= '0;
        out_track_r <= op_r.track;
      end else if (op_r.op == OP_PRESS && !hit_r && {1'b0, pop_slot} < CNT_W'(SLOTS)) begin
        out_kind_r  <= EV_PRESS;
        out_slot_r  <= pop_slot;
        out_track_r <= op_r.track;
      end else begin
        out_kind_r  <= EV_NONE;
        out_slot_r  <= '0;
        out_track_r <= '0;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/scan_code_key_slot_allocator.sv @@
// Channel   Dir  Payload                            Handshake
// in_ch     in   scan_byte[7:0]                     valid/ready
// out_ch    out  event_kind[1:0] slot[3:0]          valid/ready
//                track_index[7:0]
// Each scan byte gives exactly one result item, in input order.
// A press or a release passes through the slot engine as a fetch, one slot compare per
// cycle and an apply step; any other byte goes from its fetch straight to apply.
// A two-entry queue lets the classifier take bytes while the engine scans.
// Reset is synchronous and active low; it empties all slots and refills the
// free stack at once. A stalled result holds the engine in its apply step.
`default_nettype none
`include "scan_code_key_slot_allocator_defines.svh"
module scan_code_key_slot_allocator (
  input  wire logic     clk,
  input  wire logic     rst_n,
  sckslot_in_if.sink    in_ch,
  sckslot_out_if.source out_ch
);
  import sckslot_pkg::*;

  logic       q_push;
  op_t        q_push_data;
  logic       q_full;
  logic       q_pop;
  op_t        q_pop_data;
  logic       q_empty;
  back_stat_t stat;

  // Front: byte classification and break prefix tracking.
  sckslot_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_push_data)
  );

  // Queue between classifier and slot engine.
  sckslot_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // Back: slot scan, allocation and release.
  sckslot_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_pop_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .stat    (stat)
  );

  // The free stack never holds more entries than there are slots.
  `SCKSLOT_ASSERT_ALWAYS(a_free_bound, (!rst_n || stat.free_count <= CNT_W'(SLOTS)), "free count above slot total")
  // A result with no event carries zero slot and track fields.
  `SCKSLOT_ASSERT(a_none_zero, ((out_ch.valid && out_ch.event_kind == EV_NONE) |-> (out_ch.slot == '0 && out_ch.track_index == '0)), "event none with nonzero fields")
  // A press names a real slot.
  `SCKSLOT_ASSERT(a_press_slot, ((out_ch.valid && out_ch.event_kind == EV_PRESS) |-> ({1'b0, out_ch.slot} < CNT_W'(SLOTS))), "press names a slot out of range")
  // A press result always follows a drop of the free count by one.
  `SCKSLOT_ASSERT(a_press_pop, ((out_ch.valid && !$past(out_ch.valid) && out_ch.event_kind == EV_PRESS) |-> (stat.free_count == $past(stat.free_count) - 1'b1)), "press without free stack pop")
  // The engine takes a new operation only while it is idle.
  `SCKSLOT_ASSERT(a_pop_idle, (q_pop |-> !stat.busy), "queue popped while engine busy")
endmodule
`default_nettype wire
